### rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_SECOND  = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  localparam logic [7:0]  OPCODE_MASK     = 8'b0000_1111;
  localparam logic [7:0]  MASK_BIT        = 8'b1000_0000;
  localparam logic [7:0]  LEN7_MASK       = 8'b0111_1111;
  localparam logic [6:0]  LEN7_EXT16      = 7'd126;
  localparam logic [6:0]  LEN7_EXT64      = 7'd127;
  localparam logic [3:0]  OPC_TEXT        = 4'd1;
  localparam logic [3:0]  EXT16_BYTES     = 4'd2;
  localparam logic [3:0]  EXT64_BYTES     = 4'd8;
  localparam logic [3:0]  KEY_BYTES       = 4'd4;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [15:0] byte_count;
  } wsd_result_t;

endpackage

### rtl/core/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket deframer delivering unmasked text-frame payload.
// ----------------------------------------------------------------------------
// Accepts one byte of the framed stream per clock unless in_stall is high,
// and delivers payload bytes of text frames, unmasked, through the input
// and result registers. Header, extended length and mask key bytes produce
// no output; bytes beyond max_payload and all bytes of other frame types are
// consumed silently. The rate is one item per cycle when not stalled, set by
// the single input register feeding the parser and the single result
// register; out_stall reaches in_stall in the same cycle once both registers
// are full. Write max_payload (cfg_data) only while no frame is in flight.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_raw_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_byte,
  output logic [15:0] out_byte_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import wsd_pkg::*;

  logic        advance;
  logic        item_vld;
  logic [7:0]  item_byte;
  logic        res_vld;
  wsd_result_t res;
  logic [15:0] max_payload_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_data;
    end
  end

  wsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_raw_byte(in_raw_byte),
    .advance    (advance),
    .item_vld   (item_vld),
    .item_byte  (item_byte)
  );

  wsd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .item_byte  (item_byte),
    .max_payload(max_payload_r),
    .res_vld    (res_vld),
    .res        (res)
  );

  wsd_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_vld         (res_vld),
    .res             (res),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_last_byte   (out_last_byte),
    .out_byte_count  (out_byte_count)
  );
endmodule

### rtl/core/wsd_in_stage.sv
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one raw byte until the parser can consume it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_raw_byte,
  input  logic       advance,
  output logic       item_vld,
  output logic [7:0] item_byte
);
  logic       vld_r;
  logic [7:0] byte_r;

  assign in_stall  = vld_r && !advance;
  assign item_vld  = vld_r && advance;
  assign item_byte = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_raw_byte;
    end
  end
endmodule

### rtl/core/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header decoder and payload unmasker; one byte per consumed item.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_vld,
  input  logic [7:0]           item_byte,
  input  logic [15:0]          max_payload,
  output logic                 res_vld,
  output wsd_pkg::wsd_result_t res
);
  import wsd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic        text_r, text_nxt;
  logic        mask_r, mask_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] plen_r, plen_nxt;
  logic [63:0] pidx_r, pidx_nxt;

  logic [6:0]  len7;
  logic [63:0] ext_len;
  logic [3:0]  hidx_dec;
  logic [63:0] cnt;
  logic [7:0]  key_byte;
  logic        deliver;

  assign len7     = 7'(item_byte & LEN7_MASK);
  assign ext_len  = {plen_r[55:0], item_byte};
  assign hidx_dec = hidx_r - 4'd1;
  assign cnt      = pidx_r + 64'd1;
  // key byte 0 is the most significant byte of the shifted-in key
  assign key_byte = key_r[{~pidx_r[1:0], 3'b000} +: 8];
  assign deliver  = text_r && (pidx_r[63:16] == 48'd0) && (pidx_r[15:0] < max_payload);

  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    text_nxt  = text_r;
    mask_nxt  = mask_r;
    key_nxt   = key_r;
    plen_nxt  = plen_r;
    pidx_nxt  = pidx_r;
    res_vld   = 1'b0;
    res       = '0;
    if (item_vld) begin
      case (phase_r)
        PH_SECOND: begin
          mask_nxt = (item_byte & MASK_BIT) != 8'd0;
          plen_nxt = 64'd0;
          if (len7 == LEN7_EXT16) begin
            phase_nxt = PH_EXTLEN;
            hidx_nxt  = EXT16_BYTES;
          end else if (len7 == LEN7_EXT64) begin
            phase_nxt = PH_EXTLEN;
            hidx_nxt  = EXT64_BYTES;
          end else begin
            plen_nxt = {57'd0, len7};
            pidx_nxt = 64'd0;
            if (mask_nxt) begin
              phase_nxt = PH_MASK;
              hidx_nxt  = KEY_BYTES;
            end else if (len7 == 7'd0) begin
              phase_nxt = PH_FIRST;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_EXTLEN: begin
          plen_nxt = ext_len;
          hidx_nxt = hidx_dec;
          if (hidx_dec == 4'd0) begin
            pidx_nxt = 64'd0;
            if (mask_r) begin
              phase_nxt = PH_MASK;
              hidx_nxt  = KEY_BYTES;
            end else if (ext_len == 64'd0) begin
              phase_nxt = PH_FIRST;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_MASK: begin
          key_nxt  = {key_r[23:0], item_byte};
          hidx_nxt = hidx_dec;
          if (hidx_dec == 4'd0) begin
            phase_nxt = (plen_r == 64'd0) ? PH_FIRST : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (deliver) begin
            res_vld          = 1'b1;
            res.payload_byte = item_byte ^ key_byte;
            res.last_byte    = (cnt == plen_r) ||
                               ((cnt[63:16] == 48'd0) && (cnt[15:0] == max_payload));
            res.byte_count   = cnt[15:0];
          end
          pidx_nxt = cnt;
          if (cnt == plen_r) begin
            phase_nxt = PH_FIRST;
          end
        end
        default: begin
          text_nxt  = 4'(item_byte & OPCODE_MASK) == OPC_TEXT;
          mask_nxt  = 1'b0;
          key_nxt   = 32'd0;
          plen_nxt  = 64'd0;
          pidx_nxt  = 64'd0;
          hidx_nxt  = 4'd0;
          phase_nxt = PH_SECOND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      hidx_r  <= 4'd0;
      text_r  <= 1'b0;
      mask_r  <= 1'b0;
      key_r   <= 32'd0;
      plen_r  <= 64'd0;
      pidx_r  <= 64'd0;
    end else begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      text_r  <= text_nxt;
      mask_r  <= mask_nxt;
      key_r   <= key_nxt;
      plen_r  <= plen_nxt;
      pidx_r  <= pidx_nxt;
    end
  end
endmodule

### rtl/core/wsd_out_stage.sv
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one payload item until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_vld,
  input  wsd_pkg::wsd_result_t res,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_payload_byte,
  output logic                 out_last_byte,
  output logic [15:0]          out_byte_count
);
  import wsd_pkg::*;

  logic        vld_r;
  wsd_result_t res_r;

  // slot is free when empty or being emptied this cycle
  assign advance          = !vld_r || !out_stall;
  assign out_valid        = vld_r;
  assign out_payload_byte = res_r.payload_byte;
  assign out_last_byte    = res_r.last_byte;
  assign out_byte_count   = res_r.byte_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end
endmodule

### test/tb_websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Self-checking testbench for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
// Feeds framed byte streams (text and other opcodes, masked and unmasked,
// 7-bit, 16-bit and 64-bit length forms) through the byte channel. A
// scoreboard tracks the frame parser state, predicts every unmasked text
// payload byte, and compares each delivered item field by field. The run
// steps through several max_payload settings, including zero and the full
// 16-bit range, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BYTES  = 150;
  localparam int unsigned N_SETTINGS   = 9;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint unsigned TIMEOUT  = 64'd8_000_000;

  // First header byte: flag nibble and opcodes
  localparam logic [3:0] FLAGS_FIN = 4'b1000;
  localparam logic [3:0] FLAGS_RSV = 4'b0111;
  localparam logic [3:0] OPC_BIN   = 4'h2;
  localparam logic [3:0] OPC_PING  = 4'h9;

  typedef enum int unsigned {FORM_7, FORM_16, FORM_64} len_form_t;
  typedef enum int unsigned {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: frame parser state and queue of expected payload items
  // --------------------------------------------------------------------------
  class deframe_scoreboard;
    logic [15:0]  max_payload;
    phase_t       phase;
    logic [3:0]   header_left;
    logic         text_frame;
    logic         mask_present;
    logic [31:0]  mask_key;
    logic [63:0]  payload_length;
    logic [63:0]  payload_index;
    wsd_result_t  expected_q[$];
    int unsigned  n_results;
    int unsigned  n_errors;

    function new();
      max_payload    = MAX_PAYLOAD_RST;
      phase          = PH_FIRST;
      header_left    = '0;
      text_frame     = 1'b0;
      mask_present   = 1'b0;
      mask_key       = '0;
      payload_length = '0;
      payload_index  = '0;
      n_results      = 0;
      n_errors       = 0;
    endfunction

    function void note_error(string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
    endfunction

    function void close_header();
      payload_index = '0;
      if (mask_present) begin
        phase       = PH_MASK;
        header_left = KEY_BYTES;
      end else if (payload_length == 0) begin
        phase = PH_FIRST;
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [6:0]  len7;
      logic [63:0] cnt;
      logic [7:0]  key_byte;
      wsd_result_t item;
      case (phase)
        PH_SECOND: begin
          len7           = b[6:0];
          mask_present   = b[7];
          payload_length = '0;
          if (len7 == LEN7_EXT16) begin
            phase       = PH_EXTLEN;
            header_left = EXT16_BYTES;
          end else if (len7 == LEN7_EXT64) begin
            phase       = PH_EXTLEN;
            header_left = EXT64_BYTES;
          end else begin
            payload_length = {57'd0, len7};
            close_header();
          end
        end
        PH_EXTLEN: begin
          payload_length = {payload_length[55:0], b};
          header_left    = header_left - 4'd1;
          if (header_left == 0) close_header();
        end
        PH_MASK: begin
          mask_key    = {mask_key[23:0], b};
          header_left = header_left - 4'd1;
          if (header_left == 0) phase = (payload_length == 0) ? PH_FIRST : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (text_frame && payload_index < {48'd0, max_payload}) begin
            // key bytes rotate MSB first
            key_byte          = mask_key[8 * (3 - payload_index[1:0]) +: 8];
            cnt               = payload_index + 64'd1;
            item.payload_byte = b ^ key_byte;
            item.last_byte    = (cnt == payload_length) || (cnt == {48'd0, max_payload});
            item.byte_count   = cnt[15:0];
            expected_q.push_back(item);
          end
          payload_index = payload_index + 64'd1;
          if (payload_index == payload_length) phase = PH_FIRST;
        end
        default: begin
          text_frame     = ((b & OPCODE_MASK) == {4'd0, OPC_TEXT});
          mask_present   = 1'b0;
          mask_key       = '0;
          payload_length = '0;
          payload_index  = '0;
          header_left    = '0;
          phase          = PH_SECOND;
        end
      endcase
    endfunction

    function void check_result(wsd_result_t got);
      wsd_result_t want;
      if (expected_q.size() == 0) begin
        note_error($sformatf("unexpected item byte=%02h last=%0b count=%0d",
                             got.payload_byte, got.last_byte, got.byte_count));
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      if (got.payload_byte !== want.payload_byte || got.last_byte !== want.last_byte ||
          got.byte_count !== want.byte_count)
        note_error($sformatf({"item mismatch: exp byte=%02h last=%0b count=%0d, ",
                              "got byte=%02h last=%0b count=%0d"},
                             want.payload_byte, want.last_byte, want.byte_count,
                             got.payload_byte, got.last_byte, got.byte_count));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and channel signals
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_raw_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_last_byte;
  logic [15:0] out_byte_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  deframe_scoreboard sb = new();

  int unsigned burst_left = 0;
  logic        idle_gaps = 1'b1;
  stall_mode_t stall_mode = STALL_RANDOM;
  int unsigned stall_pct = 30;
  int unsigned stall_run = 0;
  logic        stall_hold = 1'b0;
  int unsigned n_bytes = 0;
  int unsigned n_frames = 0;
  wsd_result_t rx_item;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  websocket_frame_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_byte      (in_raw_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_last_byte    (out_last_byte),
    .out_byte_count   (out_byte_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // Receiver: check accepted items, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      rx_item.payload_byte = out_payload_byte;
      rx_item.last_byte    = out_last_byte;
      rx_item.byte_count   = out_byte_count;
      sb.check_result(rx_item);
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < stall_pct);
      default: begin
        if (stall_run == 0) begin
          stall_hold = !stall_hold;
          stall_run  = stall_hold ? $urandom_range(1, 8) : $urandom_range(1, 12);
        end
        stall_run  = stall_run - 1;
        out_stall <= stall_hold;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (idle_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 32);
    end
    in_valid    <= 1'b1;
    in_raw_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(b);
    n_bytes++;
    if (burst_left != 0) burst_left--;
  endtask

  task automatic send_header(input logic [7:0] first, input logic masked,
                             input len_form_t form, input logic [63:0] len,
                             input logic [31:0] key);
    int i;
    n_frames++;
    send_byte(first);
    case (form)
      FORM_16: send_byte({masked, LEN7_EXT16});
      FORM_64: send_byte({masked, LEN7_EXT64});
      default: send_byte({masked, len[6:0]});
    endcase
    if (form == FORM_16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == FORM_64) begin
      for (i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (masked)
      for (i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
  endtask

  task automatic send_random_payload(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    logic [7:0]  first;
    logic [63:0] len;
    len_form_t   form;
    first = 8'($urandom_range(0, 255));
    // mostly text frames; the rest are other opcodes with random flags
    if ($urandom_range(0, 99) < 75) first[3:0] = OPC_TEXT;
    else if (first[3:0] == OPC_TEXT) first[3:0] = OPC_BIN;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      form = FORM_7;
      len  = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 125)
                                             : $urandom_range(0, 24));
    end else if (pick < 85) begin
      form = FORM_16;
      len  = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                             : $urandom_range(0, 24));
    end else begin
      form = FORM_64;
      len  = 64'($urandom_range(0, 24));
    end
    send_header(first, 1'($urandom_range(0, 1)), form, len, $urandom);
    send_random_payload(len[31:0]);
  endtask

  // Hold input, wait for every expected item plus pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.max_payload = value;
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] limits [N_SETTINGS];
    int unsigned p;
    int unsigned target;
    limits = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2, 16'($urandom_range(4, 40)),
               MAX_PAYLOAD_RST, 16'($urandom), 16'd7};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty text frame, masked text with byte extremes, dropped
    // binary and ping, RSV set with FIN clear, non-minimal 16-bit length
    send_header({FLAGS_FIN, OPC_TEXT}, 1'b0, FORM_7, 64'd0, 32'd0);
    send_header({FLAGS_FIN, OPC_TEXT}, 1'b1, FORM_7, 64'd3, 32'hDEAD_BEEF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_header({FLAGS_FIN, OPC_BIN}, 1'b0, FORM_7, 64'd1, 32'd0);
    send_byte(8'h33);
    send_header({FLAGS_FIN, OPC_PING}, 1'b0, FORM_7, 64'd0, 32'd0);
    send_header({FLAGS_RSV, OPC_TEXT}, 1'b0, FORM_7, 64'd1, 32'd0);
    send_byte(8'hA5);
    send_header({FLAGS_FIN, OPC_TEXT}, 1'b0, FORM_16, 64'd2, 32'd0);
    send_byte(8'h10);
    send_byte(8'h20);

    for (p = 0; p < N_SETTINGS; p++) begin
      write_max_payload(limits[p]);
      idle_gaps  = (p % 2 == 0);
      stall_mode = stall_mode_t'(p % 3);
      stall_pct  = $urandom_range(10, 60);
      target = n_bytes + PHASE_BYTES;
      while (n_bytes < target) send_random_frame();
    end

    // 64-bit length with its top bit set: the frame never ends, so send it last
    send_header({FLAGS_FIN, OPC_TEXT}, 1'b1, FORM_64, 64'h8000_0000_0000_0005, $urandom);
    send_random_payload(20);

    drain();
    if (sb.expected_q.size() != 0)
      sb.note_error($sformatf("%0d expected items never delivered", sb.expected_q.size()));

    $display("Sent %0d stream bytes in %0d frames over %0d max_payload settings",
             n_bytes, n_frames, N_SETTINGS);
    $display("Checked %0d delivered payload items, %0d errors", sb.n_results, sb.n_errors);
    if (sb.n_errors == 0)
      $display("websocket_frame_deframer verification clean");
    else
      $display("websocket_frame_deframer verification failed");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("websocket_frame_deframer verification failed");
    $finish;
  end

endmodule
